>>> rtl/segx_pkg.sv
// ----------------------------------------------------------------------------
// Segment intersection package
// Payload types and status codes shared by the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package segx_pkg;

    // Coordinate width of every Q12.4 field.
    localparam int COORD_WIDTH = 16;

    // Input transfer: two segments, signed Q12.4 coordinates.
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] first_start_x;
        logic signed [COORD_WIDTH-1:0] first_start_y;
        logic signed [COORD_WIDTH-1:0] first_end_x;
        logic signed [COORD_WIDTH-1:0] first_end_y;
        logic signed [COORD_WIDTH-1:0] second_start_x;
        logic signed [COORD_WIDTH-1:0] second_start_y;
        logic signed [COORD_WIDTH-1:0] second_end_x;
        logic signed [COORD_WIDTH-1:0] second_end_y;
    } t_seg_in;

    // Result transfer.
    typedef struct packed {
        logic [1:0]                    hit_status;
        logic signed [COORD_WIDTH-1:0] cross_x;
        logic signed [COORD_WIDTH-1:0] cross_y;
    } t_seg_out;

    localparam logic [1:0] HIT_NONE = 2'd0;
    localparam logic [1:0] HIT_POS  = 2'd1;
    localparam logic [1:0] HIT_NEG  = 2'd2;

endpackage

>>> rtl/segx_front.sv
// ----------------------------------------------------------------------------
// Segment intersection front end
// Forms the perp-dot products, runs the window tests and classifies the pair.
// ----------------------------------------------------------------------------
module segx_front import segx_pkg::*; #(
    parameter int COORD_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_seg_in     i_item,
    input  logic [31:0] i_tolerance,
    output logic        o_valid,
    output logic        o_hit,
    output logic        o_fneg,
    output logic signed [2*COORD_WIDTH+3:0] o_aa,
    output logic signed [2*COORD_WIDTH+3:0] o_f,
    output logic signed [COORD_WIDTH:0]     o_bx,
    output logic signed [COORD_WIDTH:0]     o_by,
    output logic signed [COORD_WIDTH-1:0]   o_p2x,
    output logic signed [COORD_WIDTH-1:0]   o_p2y
);
    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * COORD_WIDTH + 4;

    logic signed [DW-1:0] ax, ay, bx, by, cx, cy;
    logic signed [2*DW-1:0] m0, m1, m2, m3, m4, m5;
    logic signed [PW-1:0] f, aa, bb, eps, lo, hi;
    logic                 r_v1, r_v2;
    logic signed [PW-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic signed [DW-1:0] r_bx, r_by;
    logic signed [COORD_WIDTH-1:0] r_p2x, r_p2y, n_p2x, n_p2y;
    logic [31:0]          r_eps;

    // Difference vectors.
    assign ax = DW'(signed'(i_item.first_end_x)) - DW'(signed'(i_item.first_start_x));
    assign ay = DW'(signed'(i_item.first_end_y)) - DW'(signed'(i_item.first_start_y));
    assign bx = DW'(signed'(i_item.second_end_x)) - DW'(signed'(i_item.second_start_x));
    assign by = DW'(signed'(i_item.second_end_y)) - DW'(signed'(i_item.second_start_y));
    assign cx = DW'(signed'(i_item.second_end_x)) - DW'(signed'(i_item.first_end_x));
    assign cy = DW'(signed'(i_item.second_end_y)) - DW'(signed'(i_item.first_end_y));
    assign n_p2x = i_item.second_start_x;
    assign n_p2y = i_item.second_start_y;

    // Full-width partial products.
    assign m0 = ay * bx;
    assign m1 = ax * by;
    assign m2 = ay * cx;
    assign m3 = ax * cy;
    assign m4 = by * cx;
    assign m5 = bx * cy;

    // Stage one: the six partial products, one multiplier each.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0  <= PW'(m0);
            r_p1  <= PW'(m1);
            r_p2  <= PW'(m2);
            r_p3  <= PW'(m3);
            r_p4  <= PW'(m4);
            r_p5  <= PW'(m5);
            r_bx  <= bx;
            r_by  <= by;
            r_p2x <= n_p2x;
            r_p2y <= n_p2y;
            r_eps <= i_tolerance;
        end
    end

    // Stage two: perp-dots and window tests.
    assign f   = r_p0 - r_p1;
    assign aa  = r_p2 - r_p3;
    assign bb  = r_p4 - r_p5;
    assign eps = PW'({1'b0, r_eps});
    assign lo  = f[PW-1] ? f - eps : -eps;
    assign hi  = f[PW-1] ? eps : f + eps;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_hit  <= (f != '0) && (aa >= lo) && (aa <= hi) && (bb >= lo) && (bb <= hi);
            o_fneg <= f[PW-1];
            o_aa   <= aa;
            o_f    <= f;
            o_bx   <= r_bx;
            o_by   <= r_by;
            o_p2x  <= r_p2x;
            o_p2y  <= r_p2y;
        end
    end

    assign o_valid = r_v2;
endmodule

>>> rtl/segx_back.sv
// ----------------------------------------------------------------------------
// Segment intersection back end
// Pipelined restoring divider for the ratio, then the crossing point.
// ----------------------------------------------------------------------------
module segx_back import segx_pkg::*; #(
    parameter int COORD_WIDTH     = 16,
    parameter int RATIO_FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic        i_hit,
    input  logic        i_fneg,
    input  logic signed [2*COORD_WIDTH+3:0] i_aa,
    input  logic signed [2*COORD_WIDTH+3:0] i_f,
    input  logic signed [COORD_WIDTH:0]     i_bx,
    input  logic signed [COORD_WIDTH:0]     i_by,
    input  logic signed [COORD_WIDTH-1:0]   i_p2x,
    input  logic signed [COORD_WIDTH-1:0]   i_p2y,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic signed [COORD_WIDTH-1:0] o_x,
    output logic signed [COORD_WIDTH-1:0] o_y
);
    localparam int PW = 2 * COORD_WIDTH + 4;
    localparam int MW = PW - 1;
    localparam int RF = RATIO_FRAC_BITS;
    localparam int NS = RF + 1;
    localparam int DW = COORD_WIDTH + 1;
    localparam int XW = DW + RF + 2;
    localparam int SW = COORD_WIDTH + 2;

    logic [NS:0]          r_v;
    logic [NS:0]          r_hit, r_neg, r_one;
    logic [MW:0]          r_rem [NS+1];
    logic [MW-1:0]        r_den [NS+1];
    logic [RF:0]          r_q   [NS+1];
    logic signed [DW-1:0] r_bx  [NS+1], r_by [NS+1];
    logic signed [COORD_WIDTH-1:0] r_px [NS+1], r_py [NS+1];

    logic [MW-1:0] na, nf;
    logic          zero_q;

    // Magnitudes; q is zero when aa is zero or its sign differs from f.
    assign na     = MW'(i_aa[PW-1] ? -i_aa : i_aa);
    assign nf     = MW'(i_fneg ? -i_f : i_f);
    assign zero_q = (i_aa == '0) || (i_aa[PW-1] != i_fneg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NS-1:0], i_valid};
        end
    end

    // Division chain: one quotient bit per stage, MSB (the integer bit) first.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {1'b0, zero_q ? MW'(0) : na};
            r_den[0] <= nf;
            r_q[0]   <= '0;
            r_hit[0] <= i_hit;
            r_neg[0] <= i_fneg;
            r_one[0] <= !zero_q && (na >= nf);
            r_bx[0]  <= i_bx;
            r_by[0]  <= i_by;
            r_px[0]  <= i_p2x;
            r_py[0]  <= i_p2y;
            for (int k = 0; k < NS; k++) begin
                if (r_rem[k] >= {1'b0, r_den[k]}) begin
                    r_rem[k+1] <= (r_rem[k] - {1'b0, r_den[k]}) << 1;
                    r_q[k+1]   <= {r_q[k][RF-1:0], 1'b1};
                end else begin
                    r_rem[k+1] <= r_rem[k] << 1;
                    r_q[k+1]   <= {r_q[k][RF-1:0], 1'b0};
                end
                r_den[k+1] <= r_den[k];
                r_hit[k+1] <= r_hit[k];
                r_neg[k+1] <= r_neg[k];
                r_one[k+1] <= r_one[k];
                r_bx[k+1]  <= r_bx[k];
                r_by[k+1]  <= r_by[k];
                r_px[k+1]  <= r_px[k];
                r_py[k+1]  <= r_py[k];
            end
        end
    end

    // Ratio complement s = 1 - q.
    logic [RF:0] q, s;
    assign q = r_one[NS] ? (RF+1)'(1) << RF : r_q[NS];
    assign s = ((RF+1)'(1) << RF) - q;

    // Scaling, one multiply per axis, registered.
    logic signed [XW-1:0] r_mx, r_my;
    logic                 r_vm, r_hm, r_nm;
    logic signed [COORD_WIDTH-1:0] r_qx, r_qy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
        end else if (i_en) begin
            r_vm <= r_v[NS];
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mx <= XW'(r_bx[NS]) * XW'(signed'({1'b0, s}));
            r_my <= XW'(r_by[NS]) * XW'(signed'({1'b0, s}));
            r_hm <= r_hit[NS];
            r_nm <= r_neg[NS];
            r_qx <= r_px[NS];
            r_qy <= r_py[NS];
        end
    end

    // Round half up, add the start point and saturate.
    logic signed [XW-1:0] rx, ry;
    logic signed [SW-1:0] sx, sy;
    localparam logic signed [SW-1:0] CMAX = SW'((1 << (COORD_WIDTH-1)) - 1);
    localparam logic signed [SW-1:0] CMIN = -CMAX - SW'(1);
    assign rx = (r_mx + (XW'(1) <<< (RF-1))) >>> RF;
    assign ry = (r_my + (XW'(1) <<< (RF-1))) >>> RF;
    assign sx = SW'(rx) + SW'(r_qx);
    assign sy = SW'(ry) + SW'(r_qy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_vm;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_status <= r_hm ? (r_nm ? HIT_NEG : HIT_POS) : HIT_NONE;
            o_x <= !r_hm ? '0 : (sx > CMAX) ? CMAX[COORD_WIDTH-1:0]
                 : (sx < CMIN) ? CMIN[COORD_WIDTH-1:0] : sx[COORD_WIDTH-1:0];
            o_y <= !r_hm ? '0 : (sy > CMAX) ? CMAX[COORD_WIDTH-1:0]
                 : (sy < CMIN) ? CMIN[COORD_WIDTH-1:0] : sy[COORD_WIDTH-1:0];
        end
    end
endmodule

>>> rtl/segx_fifo.sv
// ----------------------------------------------------------------------------
// Segment intersection result queue
// Small register queue that absorbs the pipeline contents when pop stalls.
// ----------------------------------------------------------------------------
module segx_fifo import segx_pkg::*; #(
    parameter int DEPTH = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_seg_out i_data,
    input  logic     i_pop,
    output logic     o_empty,
    output t_seg_out o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    t_seg_out        r_mem [DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_cnt;
    logic            do_pop;

    assign do_pop  = i_pop && (r_cnt != '0);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign o_count = r_cnt;

    // Pointer and count bookkeeping for each transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (do_pop) r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + CW'(i_push) - CW'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end
endmodule

>>> rtl/segment_intersection.sv
// ----------------------------------------------------------------------------
// Segment intersection
// Perp-dot segment crossing test with a pipelined ratio divider.
// ----------------------------------------------------------------------------
//  Channel  | Ports                         | Transfer when
//  input    | i_push, o_full, i_seg         | i_push && !o_full
//  result   | o_empty, i_pop, o_res         | i_pop && !o_empty
//  config   | i_cfg_we, i_cfg_data          | i_cfg_we
//
//  One pair is accepted per cycle while o_full is low; a result passes the
//  front end, the one-bit-per-stage divider chain and the output registers.
//  Reset is synchronous and empties the pipeline and the result queue.
//  The pipeline runs freely; the queue is two entries deeper than the
//  pipeline, so o_full rises only once the items in flight and the queued
//  results together fill the queue, and never while pop keeps pace.
// ----------------------------------------------------------------------------
module segment_intersection import segx_pkg::*; #(
    parameter int RATIO_FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  t_seg_in     i_seg,
    output logic        o_empty,
    input  logic        i_pop,
    output t_seg_out    o_res,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data
);
    localparam int LAT   = RATIO_FRAC_BITS + 6;
    localparam int DEPTH = LAT + 2;
    localparam int CW    = $clog2(DEPTH+1);
    localparam int PW    = 2 * COORD_WIDTH + 4;

    logic [31:0] r_tol;
    logic        acc, f_v, f_hit, f_neg, b_v;
    logic signed [PW-1:0]          f_aa, f_f;
    logic signed [COORD_WIDTH:0]   f_bx, f_by;
    logic signed [COORD_WIDTH-1:0] f_px, f_py, b_x, b_y;
    logic [1:0]  b_st;
    logic [CW-1:0] cnt;
    logic [$clog2(LAT+2)-1:0] r_fly;
    t_seg_out    res;

    // Tolerance register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_data;
        end
    end

    // Items in flight in the pipeline.
    assign acc = i_push && !o_full;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fly <= '0;
        end else begin
            r_fly <= r_fly + ($bits(r_fly))'(acc) - ($bits(r_fly))'(b_v);
        end
    end
    assign o_full = (32'(cnt) + 32'(r_fly)) >= 32'(DEPTH);

    segx_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_clk, .i_rst_n, .i_en(1'b1), .i_valid(acc), .i_item(i_seg),
        .i_tolerance(r_tol), .o_valid(f_v), .o_hit(f_hit), .o_fneg(f_neg),
        .o_aa(f_aa), .o_f(f_f), .o_bx(f_bx), .o_by(f_by),
        .o_p2x(f_px), .o_p2y(f_py)
    );

    segx_back #(.COORD_WIDTH(COORD_WIDTH), .RATIO_FRAC_BITS(RATIO_FRAC_BITS)) u_back (
        .i_clk, .i_rst_n, .i_en(1'b1), .i_valid(f_v), .i_hit(f_hit),
        .i_fneg(f_neg), .i_aa(f_aa), .i_f(f_f), .i_bx(f_bx), .i_by(f_by),
        .i_p2x(f_px), .i_p2y(f_py), .o_valid(b_v), .o_status(b_st),
        .o_x(b_x), .o_y(b_y)
    );

    assign res.hit_status = b_st;
    assign res.cross_x    = b_x;
    assign res.cross_y    = b_y;

    segx_fifo #(.DEPTH(DEPTH)) u_fifo (
        .i_clk, .i_rst_n, .i_push(b_v), .i_data(res), .i_pop,
        .o_empty, .o_data(o_res), .o_count(cnt)
    );

    // The queue never overflows, never yields the reserved status, and a miss carries a zero point.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_v |-> (32'(cnt) < 32'(DEPTH))) else $error("result queue overflow");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_res.hit_status != 2'd3)) else $error("reserved status");
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_v && b_st == HIT_NONE) |-> (b_x == '0 && b_y == '0))
        else $error("miss with nonzero point");
endmodule

>>> tb/sv/segment_intersection_test.sv
// ----------------------------------------------------------------------------
// Segment intersection testbench
// Drives segment pairs through the push/full queue, predicts each crossing
// result from the perp-dot rules and checks every popped result in order.
// ----------------------------------------------------------------------------
module segment_intersection_test;
    import segx_pkg::*;

    localparam int LATENCY = 22;
    localparam int FRAC    = 16;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_push;
    logic        o_full;
    t_seg_in     i_seg;
    logic        o_empty;
    logic        i_pop;
    t_seg_out    o_res;
    logic        i_cfg_we;
    logic [31:0] i_cfg_data;

    t_seg_in     pair_queue[$];
    t_seg_out    crossing_queue[$];
    logic [31:0] tol;
    int          errors;
    int          send_gap;
    int          recv_gap;
    int          hold_off;
    bit          stimulus_done;

    segment_intersection uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .o_full     (o_full),
        .i_seg      (i_seg),
        .o_empty    (o_empty),
        .i_pop      (i_pop),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Predicts the crossing result of one segment pair under tolerance t.
    function automatic t_seg_out predict_crossing(t_seg_in p, logic [31:0] t);
        t_seg_out    r;
        longint      ax, ay, bx, by, cx, cy, f, aa, bb, lo, hi, eps, half, ox, oy;
        longint      na, nf, q, s;
        r   = '0;
        eps = longint'(t);
        ax = longint'(p.first_end_x) - longint'(p.first_start_x);
        ay = longint'(p.first_end_y) - longint'(p.first_start_y);
        bx = longint'(p.second_end_x) - longint'(p.second_start_x);
        by = longint'(p.second_end_y) - longint'(p.second_start_y);
        cx = longint'(p.second_end_x) - longint'(p.first_end_x);
        cy = longint'(p.second_end_y) - longint'(p.first_end_y);
        f  = ay * bx - ax * by;
        if (f == 0) return r;
        aa = ay * cx - ax * cy;
        bb = by * cx - bx * cy;
        if (f < 0) begin
            lo = f - eps;
            hi = eps;
        end else begin
            lo = -eps;
            hi = f + eps;
        end
        if (!(aa >= lo && aa <= hi && bb >= lo && bb <= hi)) return r;
        if (aa == 0 || ((aa < 0) != (f < 0))) begin
            q = 0;
        end else begin
            na = (aa < 0) ? -aa : aa;
            nf = (f < 0) ? -f : f;
            q  = (na >= nf) ? (longint'(1) << FRAC) : ((na << FRAC) / nf);
        end
        s    = (longint'(1) << FRAC) - q;
        half = longint'(1) << (FRAC - 1);
        // Arithmetic shift floors, which gives the tie toward plus infinity.
        ox = ((bx * s + half) >>> FRAC) + longint'(p.second_start_x);
        oy = ((by * s + half) >>> FRAC) + longint'(p.second_start_y);
        if (ox > 32767) ox = 32767;
        if (ox < -32768) ox = -32768;
        if (oy > 32767) oy = 32767;
        if (oy < -32768) oy = -32768;
        r.hit_status = (f > 0) ? HIT_POS : HIT_NEG;
        r.cross_x    = ox[15:0];
        r.cross_y    = oy[15:0];
        return r;
    endfunction

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom);
            1:       return 16'($signed($urandom_range(0, 512)) - 256);
            2:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return 16'($signed($urandom_range(0, 8000)) - 4000);
        endcase
    endfunction

    function automatic t_seg_in random_pair();
        t_seg_in p;
        int      m;
        p.first_start_x  = rand_coord();
        p.first_start_y  = rand_coord();
        p.first_end_x    = rand_coord();
        p.first_end_y    = rand_coord();
        p.second_start_x = rand_coord();
        p.second_start_y = rand_coord();
        p.second_end_x   = rand_coord();
        p.second_end_y   = rand_coord();
        m = $urandom_range(0, 9);
        // Crossing pairs: a cross centred on a common point.
        if (m < 5) begin
            p.first_end_x    = 16'(-int'(p.first_start_x) / 2 * 2 / 2);
            p.first_start_x  = 16'($signed($urandom_range(0, 4000)) - 2000);
            p.first_start_y  = 16'($signed($urandom_range(0, 4000)) - 2000);
            p.first_end_x    = -p.first_start_x;
            p.first_end_y    = -p.first_start_y;
            p.second_start_x = 16'($signed($urandom_range(0, 4000)) - 2000);
            p.second_start_y = 16'($signed($urandom_range(0, 4000)) - 2000);
            p.second_end_x   = -p.second_start_x;
            p.second_end_y   = -p.second_start_y;
        end else if (m == 5) begin
            // Parallel: same direction vector.
            p.second_end_x = 16'(int'(p.second_start_x) + int'(p.first_end_x)
                                 - int'(p.first_start_x));
            p.second_end_y = 16'(int'(p.second_start_y) + int'(p.first_end_y)
                                 - int'(p.first_start_y));
        end
        return p;
    endfunction

    function automatic t_seg_in make_pair(int a, int b, int c, int d,
                                          int e, int g, int h, int k);
        t_seg_in p;
        p = {16'(a), 16'(b), 16'(c), 16'(d), 16'(e), 16'(g), 16'(h), 16'(k)};
        return p;
    endfunction

    // Writes the tolerance register while the block is idle.
    task automatic write_tolerance(logic [31:0] v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        tol        <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pair_queue.size() != 0 || i_push || crossing_queue.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Stimulus and configuration phases.
    initial begin
        logic [31:0] tol_set[5];
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        tol = '0;
        errors = 0;
        stimulus_done = 1'b0;
        hold_off = 0;
        tol_set = '{32'd0, 32'd200, 32'hffff_ffff, 32'd5000, 32'd1};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Directed: extremes, parallel, endpoint touches, sign of f.
        pair_queue.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        pair_queue.push_back(make_pair(-16, 0, 16, 0, 0, -16, 0, 16));
        pair_queue.push_back(make_pair(0, -16, 0, 16, -16, 0, 16, 0));
        pair_queue.push_back(make_pair(0, 0, 32, 0, 0, 16, 32, 16));
        pair_queue.push_back(make_pair(0, 0, 32, 0, 32, 0, 32, 32));
        pair_queue.push_back(make_pair(0, 0, 32, 0, 0, 0, 0, 32));
        pair_queue.push_back(make_pair(0, 0, 32, 0, 16, 1, 16, 32));
        pair_queue.push_back(make_pair(-32768, -32768, 32767, 32767,
                                       -32768, 32767, 32767, -32768));
        pair_queue.push_back(make_pair(32767, -32768, -32768, 32767,
                                       32767, 32767, -32768, -32768));
        pair_queue.push_back(make_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
        pair_queue.push_back(make_pair(32767, 32767, 32767, 32767, 0, 0, 5, 5));
        pair_queue.push_back(make_pair(0, 0, 3, 7, 1, 5, 2, -1));
        pair_queue.push_back(make_pair(-32768, -32768, -32768, 32767,
                                       -32768, 32767, 32767, 32767));
        pair_queue.push_back(make_pair(0, 0, 100, 0, 50, 0, 50, 3));
        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0) write_tolerance(tol_set[ph]);
            for (int i = 0; i < 80; i++) pair_queue.push_back(random_pair());
            // Long receiver hold-off while the sender keeps offering.
            if (ph == 1) hold_off = 200;
            wait_drained();
        end
        stimulus_done = 1'b1;
    end

    // Driver: offers the oldest pending pair with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_push   <= 1'b0;
            i_seg    <= '0;
            send_gap <= 0;
        end else if (i_push && !o_full) begin
            crossing_queue.push_back(predict_crossing(i_seg, tol));
            void'(pair_queue.pop_front());
            if (pair_queue.size() != 0 && $urandom_range(0, 3) == 0) begin
                i_push   <= 1'b0;
                send_gap <= $urandom_range(1, 17);
            end else if (pair_queue.size() != 0) begin
                i_seg <= pair_queue[0];
            end else begin
                i_push <= 1'b0;
            end
        end else if (!i_push) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (pair_queue.size() != 0) begin
                i_push <= 1'b1;
                i_seg  <= pair_queue[0];
            end
        end
    end

    // Monitor: pops results with random stalls and checks them in order.
    always @(posedge i_clk) begin
        t_seg_out exp_res;
        if (!i_rst_n) begin
            i_pop    <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (i_pop && !o_empty) begin
                if (crossing_queue.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, o_res);
                    errors <= errors + 1;
                end else begin
                    exp_res = crossing_queue.pop_front();
                    if (o_res.hit_status !== exp_res.hit_status ||
                        o_res.cross_x !== exp_res.cross_x ||
                        o_res.cross_y !== exp_res.cross_y) begin
                        $display("%0t: mismatch expected %p actual %p",
                                 $time, exp_res, o_res);
                        errors <= errors + 1;
                    end
                end
            end
            if (hold_off > 0) begin
                i_pop    <= 1'b0;
                hold_off <= hold_off - 1;
            end else if (recv_gap > 0) begin
                i_pop    <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else if (i_pop && !o_empty && $urandom_range(0, 3) == 0) begin
                i_pop    <= 1'b0;
                recv_gap <= $urandom_range(0, 17);
            end else begin
                i_pop <= 1'b1;
            end
        end
    end

    // End of run.
    initial begin
        wait (stimulus_done);
        if (errors == 0 && crossing_queue.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Timeout.
    initial begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
